// File: src/text_console_writer_core_defines.svh
// ----------------------------------------------------------------------------
// Text console writer assertion macros
// Shared property shapes for the console checker.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_WRITER_CORE_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_CORE_DEFINES_SVH

// Same-cycle implication, ignored while reset is high.
`define TCW_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tcw check failed: same-cycle rule");

// Next-cycle implication, ignored while reset is high.
`define TCW_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tcw check failed: next-cycle rule");

// What must show in the cycle after a reset cycle.
`define TCW_ASSERT_AFTER_RESET(lbl, clk, rst, cons) \
   lbl: assert property (@(posedge clk) (rst) |=> (cons)) \
      else $error("tcw check failed: after reset");

`endif

// File: src/tcw_pkg.sv
// ----------------------------------------------------------------------------
// Text console writer package
// Screen geometry, request and character codes, and the command format.
// ----------------------------------------------------------------------------
package tcw_pkg;

   // Screen geometry
   localparam int COLUMNS   = 80;
   localparam int ROWS      = 25;
   localparam int TAB_WIDTH = 8;
   localparam int CELLS     = COLUMNS * ROWS;

   localparam int CELL_AW   = $clog2(CELLS);
   localparam int COL_W     = $clog2(COLUMNS);
   localparam int ROW_W     = $clog2(ROWS);
   localparam int TAB_W     = $clog2(COLUMNS + TAB_WIDTH);
   localparam int TAB_STOPS = (COLUMNS + TAB_WIDTH - 1) / TAB_WIDTH;

   // Fixed field widths
   localparam int REQ_W  = 2;
   localparam int CHAR_W = 8;
   localparam int ATTR_W = 8;
   localparam int IDX_W  = 11;
   localparam int POS_W  = 11;
   localparam int CELL_W = CHAR_W + ATTR_W;

   // Command queue
   localparam int QDEPTH = 2;
   localparam int QP_W   = $clog2(QDEPTH);
   localparam int QC_W   = $clog2(QDEPTH + 1);

   localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h0F;

   // Request codes
   localparam logic [REQ_W-1:0] REQ_WRITE = 2'd0;
   localparam logic [REQ_W-1:0] REQ_READ  = 2'd1;
   localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

   // Control characters
   localparam logic [CHAR_W-1:0] CH_BS  = 8'h08;
   localparam logic [CHAR_W-1:0] CH_TAB = 8'h09;
   localparam logic [CHAR_W-1:0] CH_LF  = 8'h0A;
   localparam logic [CHAR_W-1:0] CH_CR  = 8'h0D;

   typedef enum logic [2:0] {
      OP_PUTC,
      OP_BKSP,
      OP_TAB,
      OP_CR,
      OP_LF,
      OP_READ,
      OP_CLEAR,
      OP_NOP
   } op_type;

   typedef struct packed {
      op_type              op;
      logic [CHAR_W-1:0]   ch;
      logic [IDX_W-1:0]    idx;
      logic [ATTR_W-1:0]   attr;
   } cmd_type;

   typedef struct packed {
      logic                we;
      logic [CELL_AW-1:0]  waddr;
      logic [CELL_W-1:0]   wdata;
      logic                re;
      logic [CELL_AW-1:0]  raddr;
   } ram_req_type;

endpackage

// File: src/text_console_writer_core.sv
// ----------------------------------------------------------------------------
// Text console writer core
// Character-cell screen with cursor, control characters and scrolling.
// ----------------------------------------------------------------------------
// A request is taken at a clock edge where start is high and busy is low, and
// every request yields exactly one result, shown for a single cycle with
// rsp_valid high; the receiver cannot stall it, so sample it on that edge.
// Results come back in request order. A two-entry command queue sits between
// the request decoder and the screen engine, so start may be taken while the
// engine still works; busy rises once the queue is full. Cost per request is
// set by the single cell RAM: a printable character, tab, carriage return,
// line feed, cell read or unused request passes through the dispatch and
// result states; a backspace also takes a state that writes the cell back
// after reading it (not at column zero, where it does nothing). A request
// that moves the cursor off the last usable row scrolls the screen, copying
// one cell per cycle through the RAM after a priming read. A clear request
// blanks one cell per cycle. After reset the RAM is blanked the same way,
// with busy high until it is done, before the first request is taken;
// csr writes are taken at any time. The cursor never rests on the bottom row.
// ----------------------------------------------------------------------------
module text_console_writer_core import tcw_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   // request channel
   input  logic              start,
   output logic              busy,
   input  logic [REQ_W-1:0]  req_type,
   input  logic [CHAR_W-1:0] req_char_code,
   input  logic [IDX_W-1:0]  req_cell_index,
   // result channel
   output logic              rsp_valid,
   output logic [POS_W-1:0]  rsp_cursor_pos,
   output logic [CHAR_W-1:0] rsp_cell_char,
   output logic [ATTR_W-1:0] rsp_cell_attr,
   // attribute register
   input  logic              csr_wr_en,
   input  logic [ATTR_W-1:0] csr_wr_data
);

   logic [ATTR_W-1:0] text_attr_ff, text_attr_in;

   logic              q_full;
   logic              q_empty;
   logic              push;
   logic              pop;
   logic              init_active;
   cmd_type           push_cmd;
   cmd_type           head_cmd;
   ram_req_type       ram_req;
   logic [CELL_W-1:0] ram_rdata;

   // attribute stored with each printed character
   assign text_attr_in = csr_wr_en ? csr_wr_data : text_attr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         text_attr_ff <= ATTR_RESET;
      end else begin
         text_attr_ff <= text_attr_in;
      end
   end

   // decode the request; the attribute travels with the item
   tcw_front u_front (
      .start          (start),
      .busy           (busy),
      .req_type       (req_type),
      .req_char_code  (req_char_code),
      .req_cell_index (req_cell_index),
      .text_attr      (text_attr_ff),
      .q_full         (q_full),
      .init_active    (init_active),
      .push           (push),
      .push_cmd       (push_cmd)
   );

   // decouple decoding from screen work
   tcw_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head_cmd (head_cmd),
      .empty    (q_empty),
      .full     (q_full)
   );

   // cursor, scrolling, clearing and result generation
   tcw_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_empty        (q_empty),
      .q_cmd          (head_cmd),
      .pop            (pop),
      .ram_req        (ram_req),
      .ram_rdata      (ram_rdata),
      .init_active    (init_active),
      .rsp_valid      (rsp_valid),
      .rsp_cursor_pos (rsp_cursor_pos),
      .rsp_cell_char  (rsp_cell_char),
      .rsp_cell_attr  (rsp_cell_attr)
   );

   // screen cells: attribute in the high byte, character in the low byte
   tcw_ram #(
      .WIDTH (CELL_W),
      .DEPTH (CELLS)
   ) u_cells (
      .clock   (clock),
      .wr_en   (ram_req.we),
      .wr_addr (ram_req.waddr),
      .wr_data (ram_req.wdata),
      .rd_en   (ram_req.re),
      .rd_addr (ram_req.raddr),
      .rd_data (ram_rdata)
   );

endmodule

// File: src/tcw_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tcw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/tcw_front.sv
// ----------------------------------------------------------------------------
// Console front end
// Accepts requests and decodes them into console commands.
// ----------------------------------------------------------------------------
module tcw_front import tcw_pkg::*; (
   input  logic              start,
   output logic              busy,
   input  logic [REQ_W-1:0]  req_type,
   input  logic [CHAR_W-1:0] req_char_code,
   input  logic [IDX_W-1:0]  req_cell_index,
   input  logic [ATTR_W-1:0] text_attr,
   input  logic              q_full,
   input  logic              init_active,
   output logic              push,
   output cmd_type           push_cmd
);

   // hold off while the queue is full or the screen is still being blanked
   assign busy = q_full | init_active;
   assign push = start & ~busy;

   always_comb begin
      push_cmd.ch   = req_char_code;
      push_cmd.idx  = req_cell_index;
      push_cmd.attr = text_attr;
      case (req_type)
         REQ_WRITE: begin
            case (req_char_code)
               CH_BS:   push_cmd.op = OP_BKSP;
               CH_TAB:  push_cmd.op = OP_TAB;
               CH_CR:   push_cmd.op = OP_CR;
               CH_LF:   push_cmd.op = OP_LF;
               default: push_cmd.op = OP_PUTC;
            endcase
         end
         REQ_READ:  push_cmd.op = OP_READ;
         REQ_CLEAR: push_cmd.op = OP_CLEAR;
         default:   push_cmd.op = OP_NOP;
      endcase
   end

endmodule

// File: src/tcw_queue.sv
// ----------------------------------------------------------------------------
// Console command queue
// Short FIFO between the decoder and the screen engine.
// ----------------------------------------------------------------------------
module tcw_queue import tcw_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   input  logic    pop,
   output cmd_type head_cmd,
   output logic    empty,
   output logic    full
);

   cmd_type           entry_ff [QDEPTH];
   logic [QP_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QP_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QC_W-1:0]   count_ff, count_in;

   localparam logic [QP_W-1:0] PTR_LAST = QP_W'(QDEPTH - 1);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   assign head_cmd = entry_ff[rd_ptr_ff];
   assign empty    = (count_ff == '0);
   assign full     = (count_ff == QC_W'(QDEPTH));

endmodule

// File: src/tcw_back.sv
// ----------------------------------------------------------------------------
// Console screen engine
// Runs commands against the cell RAM, keeps the cursor, emits results.
// ----------------------------------------------------------------------------
module tcw_back import tcw_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_empty,
   input  cmd_type            q_cmd,
   output logic               pop,
   output ram_req_type        ram_req,
   input  logic [CELL_W-1:0]  ram_rdata,
   output logic               init_active,
   output logic               rsp_valid,
   output logic [POS_W-1:0]   rsp_cursor_pos,
   output logic [CHAR_W-1:0]  rsp_cell_char,
   output logic [ATTR_W-1:0]  rsp_cell_attr
);

   typedef enum logic [2:0] {
      ST_SWEEP,
      ST_IDLE,
      ST_BKSP,
      ST_PRIME,
      ST_SCROLL,
      ST_RESP
   } state_type;

   localparam logic [COL_W-1:0]   COL_LAST  = COL_W'(COLUMNS - 1);
   localparam logic [ROW_W-1:0]   ROW_LAST  = ROW_W'(ROWS - 2);
   localparam logic [CELL_AW-1:0] CELL_LAST = CELL_AW'(CELLS - 1);
   localparam int                 KEEP_CELLS = (ROWS - 1) * COLUMNS;

   state_type            state_ff, state_in;
   logic [COL_W-1:0]     col_ff, col_in;
   logic [ROW_W-1:0]     row_ff, row_in;
   logic [CELL_AW-1:0]   cnt_ff, cnt_in;
   logic                 init_ff, init_in;
   logic                 has_cell_ff, has_cell_in;
   logic [CELL_AW-1:0]   bk_addr_ff, bk_addr_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [POS_W-1:0]     rsp_pos_ff, rsp_pos_in;
   logic [CHAR_W-1:0]    rsp_char_ff, rsp_char_in;
   logic [ATTR_W-1:0]    rsp_attr_ff, rsp_attr_in;

   logic [CELL_AW-1:0]   cur_lin;
   logic [TAB_W-1:0]     tab_next;
   logic [CELL_AW:0]     src_next;
   logic                 adv;

   // next multiple of the tab width above a column
   function automatic logic [TAB_W-1:0] tab_stop(input logic [COL_W-1:0] col);
      logic [TAB_W-1:0] stop;
      stop = TAB_W'(TAB_WIDTH);
      for (int k = 1; k < TAB_STOPS; k++) begin
         if (int'(col) >= k * TAB_WIDTH) begin
            stop = TAB_W'((k + 1) * TAB_WIDTH);
         end
      end
      return stop;
   endfunction

   assign cur_lin  = CELL_AW'(row_ff) * CELL_AW'(COLUMNS) + CELL_AW'(col_ff);
   assign tab_next = tab_stop(col_ff);
   assign src_next = {1'b0, cnt_ff} + (CELL_AW + 1)'(COLUMNS + 1);

   always_comb begin
      state_in     = state_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      cnt_in       = cnt_ff;
      init_in      = init_ff;
      has_cell_in  = has_cell_ff;
      bk_addr_in   = bk_addr_ff;
      rsp_valid_in = 1'b0;
      rsp_pos_in   = rsp_pos_ff;
      rsp_char_in  = rsp_char_ff;
      rsp_attr_in  = rsp_attr_ff;
      pop          = 1'b0;
      ram_req      = '0;
      adv          = 1'b0;

      case (state_ff)
         ST_SWEEP: begin
            // blank one cell per cycle
            ram_req.we    = 1'b1;
            ram_req.waddr = cnt_ff;
            ram_req.wdata = '0;
            if (cnt_ff == CELL_LAST) begin
               cnt_in      = '0;
               has_cell_in = 1'b0;
               init_in     = 1'b0;
               state_in    = init_ff ? ST_IDLE : ST_RESP;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end

         ST_IDLE: begin
            if (!q_empty) begin
               pop         = 1'b1;
               has_cell_in = 1'b0;
               state_in    = ST_RESP;
               case (q_cmd.op)
                  OP_PUTC: begin
                     ram_req.we    = 1'b1;
                     ram_req.waddr = cur_lin;
                     ram_req.wdata = {q_cmd.attr, q_cmd.ch};
                     if (col_ff == COL_LAST) begin
                        col_in = '0;
                        adv    = 1'b1;
                     end else begin
                        col_in = col_ff + 1'b1;
                     end
                  end
                  OP_TAB: begin
                     if (int'(tab_next) >= COLUMNS) begin
                        col_in = '0;
                        adv    = 1'b1;
                     end else begin
                        col_in = COL_W'(tab_next);
                     end
                  end
                  OP_CR: begin
                     col_in = '0;
                  end
                  OP_LF: begin
                     col_in = '0;
                     adv    = 1'b1;
                  end
                  OP_BKSP: begin
                     // step left, then rewrite that cell with its character dropped
                     if (col_ff != '0) begin
                        col_in        = col_ff - 1'b1;
                        ram_req.re    = 1'b1;
                        ram_req.raddr = cur_lin - 1'b1;
                        bk_addr_in    = cur_lin - 1'b1;
                        state_in      = ST_BKSP;
                     end
                  end
                  OP_READ: begin
                     if (int'(q_cmd.idx) < CELLS) begin
                        ram_req.re    = 1'b1;
                        ram_req.raddr = CELL_AW'(q_cmd.idx);
                        has_cell_in   = 1'b1;
                     end
                  end
                  OP_CLEAR: begin
                     col_in   = '0;
                     row_in   = '0;
                     cnt_in   = '0;
                     state_in = ST_SWEEP;
                  end
                  default: begin
                  end
               endcase
               // a row step from the last usable row scrolls instead
               if (adv) begin
                  if (row_ff == ROW_LAST) begin
                     state_in = ST_PRIME;
                  end else begin
                     row_in = row_ff + 1'b1;
                  end
               end
            end
         end

         ST_BKSP: begin
            ram_req.we    = 1'b1;
            ram_req.waddr = bk_addr_ff;
            ram_req.wdata = {ram_rdata[CELL_W-1:CHAR_W], CHAR_W'(0)};
            state_in      = ST_RESP;
         end

         ST_PRIME: begin
            ram_req.re    = 1'b1;
            ram_req.raddr = CELL_AW'(COLUMNS);
            cnt_in        = '0;
            state_in      = ST_SCROLL;
         end

         ST_SCROLL: begin
            // copy the cell one row below, blank the bottom row
            ram_req.we    = 1'b1;
            ram_req.waddr = cnt_ff;
            ram_req.wdata = (int'(cnt_ff) < KEEP_CELLS) ? ram_rdata : '0;
            if (int'(src_next) < CELLS) begin
               ram_req.re    = 1'b1;
               ram_req.raddr = CELL_AW'(src_next);
            end
            if (cnt_ff == CELL_LAST) begin
               cnt_in   = '0;
               state_in = ST_RESP;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end

         ST_RESP: begin
            rsp_valid_in = 1'b1;
            rsp_pos_in   = POS_W'(cur_lin);
            rsp_char_in  = has_cell_ff ? ram_rdata[CHAR_W-1:0] : '0;
            rsp_attr_in  = has_cell_ff ? ram_rdata[CELL_W-1:CHAR_W] : '0;
            state_in     = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_SWEEP;
         col_ff       <= '0;
         row_ff       <= '0;
         cnt_ff       <= '0;
         init_ff      <= 1'b1;
         has_cell_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         cnt_ff       <= cnt_in;
         init_ff      <= init_in;
         has_cell_ff  <= has_cell_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      bk_addr_ff  <= bk_addr_in;
      rsp_pos_ff  <= rsp_pos_in;
      rsp_char_ff <= rsp_char_in;
      rsp_attr_ff <= rsp_attr_in;
   end

   assign init_active    = init_ff;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_cursor_pos = rsp_pos_ff;
   assign rsp_cell_char  = rsp_char_ff;
   assign rsp_cell_attr  = rsp_attr_ff;

endmodule

// File: src/tcw_checker.sv
// ----------------------------------------------------------------------------
// Text console writer checker
// Port-level checks on reset behavior, result spacing and cursor range.
// ----------------------------------------------------------------------------
`include "text_console_writer_core_defines.svh"

module tcw_checker import tcw_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              busy,
   input logic              rsp_valid,
   input logic [POS_W-1:0]  rsp_cursor_pos
);

   logic pos_in_view;

   assign pos_in_view = (int'(rsp_cursor_pos) < (ROWS - 1) * COLUMNS);

   // the screen is being blanked right after reset
   `TCW_ASSERT_AFTER_RESET(a_busy_after_reset, clock, reset, busy)

   // no stray result out of reset
   `TCW_ASSERT_AFTER_RESET(a_no_rsp_after_reset, clock, reset, !rsp_valid)

   // results are never strobed back to back
   `TCW_ASSERT_NEXT(a_rsp_spaced, clock, reset, rsp_valid, !rsp_valid)

   // the reported cursor never sits on the bottom row
   `TCW_ASSERT_IMPL(a_cursor_above_bottom, clock, reset, rsp_valid, pos_in_view)

endmodule

bind text_console_writer_core tcw_checker u_tcw_checker (.*);

// File: tb/text_console_writer_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console writer core testbench
// Drives write, read, clear and unused requests into the console core and
// compares every result with a cycle-free shadow of the screen and cursor.
// A short table of known cases comes first, then random text with control
// characters, cell reads and clears under several attribute settings.
// ----------------------------------------------------------------------------
module text_console_writer_core_tb;
   import tcw_pkg::*;

   localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

   localparam int HALF_PERIOD     = 4;
   localparam int ITEMS_PER_PHASE = 256;
   localparam int ATTR_PHASES     = 5;
   localparam int OPENING_ROWS    = 18;
   localparam int MAX_CELL_INDEX  = (1 << IDX_W) - 1;
   localparam int TAIL_CYCLES     = 50;
   // Worst case is every item paying a full scroll plus the longest gap;
   // take that several times over.
   localparam longint RUN_LIMIT_NS = 100_000_000;

   typedef struct packed {
      logic [POS_W-1:0]  pos;
      logic [CHAR_W-1:0] ch;
      logic [ATTR_W-1:0] attr;
   } cell_report_type;

   typedef struct packed {
      logic [REQ_W-1:0]  kind;
      logic [CHAR_W-1:0] code;
      logic [IDX_W-1:0]  addr;
      logic              typed;
      cell_report_type   want;
   } opening_row_type;

   // ----------------------------------------------------------------------
   // Block signals; the inputs are at known values from time zero
   // ----------------------------------------------------------------------
   logic              clock          = 1'b0;
   logic              reset          = 1'b1;
   logic              start          = 1'b0;
   logic              busy;
   logic [REQ_W-1:0]  req_type       = REQ_WRITE;
   logic [CHAR_W-1:0] req_char_code  = '0;
   logic [IDX_W-1:0]  req_cell_index = '0;
   logic              rsp_valid;
   logic [POS_W-1:0]  rsp_cursor_pos;
   logic [CHAR_W-1:0] rsp_cell_char;
   logic [ATTR_W-1:0] rsp_cell_attr;
   logic              csr_wr_en      = 1'b0;
   logic [ATTR_W-1:0] csr_wr_data    = '0;

   text_console_writer_core dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_type       (req_type),
      .req_char_code  (req_char_code),
      .req_cell_index (req_cell_index),
      .rsp_valid      (rsp_valid),
      .rsp_cursor_pos (rsp_cursor_pos),
      .rsp_cell_char  (rsp_cell_char),
      .rsp_cell_attr  (rsp_cell_attr),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data)
   );

   always #(HALF_PERIOD) clock = ~clock;

   // ----------------------------------------------------------------------
   // Shadow console: screen cells, cursor and attribute register
   // ----------------------------------------------------------------------
   logic [CELL_W-1:0] shadow_cells [CELLS];
   int unsigned       shadow_col;
   int unsigned       shadow_row;
   logic [ATTR_W-1:0] shadow_attr;

   cell_report_type awaited_reports [$];

   int error_count   = 0;
   int items_sent    = 0;
   int reports_seen  = 0;
   int scroll_count  = 0;
   int clear_count   = 0;
   int read_count    = 0;

   function automatic void shadow_reset();
      for (int i = 0; i < CELLS; i++) shadow_cells[i] = '0;
      shadow_col  = 0;
      shadow_row  = 0;
      shadow_attr = ATTR_RESET;
   endfunction

   // Move every row up by one and blank the bottom row.
   function automatic void shadow_scroll();
      for (int i = 0; i < CELLS - COLUMNS; i++) shadow_cells[i] = shadow_cells[i + COLUMNS];
      for (int i = CELLS - COLUMNS; i < CELLS; i++) shadow_cells[i] = '0;
      shadow_row   = shadow_row - 1;
      scroll_count = scroll_count + 1;
   endfunction

   function automatic void shadow_put_byte(input logic [CHAR_W-1:0] code);
      int unsigned here;
      here = shadow_row * COLUMNS + shadow_col;
      case (code)
         CH_BS: begin
            // Step left only when not already at column zero; keep the attribute.
            if (shadow_col > 0) begin
               shadow_col = shadow_col - 1;
               here       = shadow_row * COLUMNS + shadow_col;
               if (here < CELLS) shadow_cells[here][CHAR_W-1:0] = '0;
            end
         end
         CH_TAB: shadow_col = (shadow_col / TAB_WIDTH + 1) * TAB_WIDTH;
         CH_CR:  shadow_col = 0;
         CH_LF: begin
            shadow_col = 0;
            shadow_row = shadow_row + 1;
         end
         default: begin
            // Any other byte, zero included, is printed with the current attribute.
            if (here < CELLS) shadow_cells[here] = {shadow_attr, code};
            shadow_col = shadow_col + 1;
         end
      endcase
      if (shadow_col >= COLUMNS) begin
         shadow_col = 0;
         shadow_row = shadow_row + 1;
      end
      // The cursor never rests on the bottom row.
      if (shadow_row >= ROWS - 1) shadow_scroll();
   endfunction

   // Apply one request to the shadow and return the result it must produce.
   function automatic cell_report_type console_apply(input logic [REQ_W-1:0]  kind,
                                                     input logic [CHAR_W-1:0] code,
                                                     input logic [IDX_W-1:0]  addr);
      cell_report_type view;
      view = '0;
      case (kind)
         REQ_WRITE: shadow_put_byte(code);
         REQ_READ: begin
            read_count = read_count + 1;
            // Out-of-range addresses read back as a blank cell.
            if (addr < CELLS) begin
               view.ch   = shadow_cells[addr][CHAR_W-1:0];
               view.attr = shadow_cells[addr][CELL_W-1:CHAR_W];
            end
         end
         REQ_CLEAR: begin
            clear_count = clear_count + 1;
            for (int i = 0; i < CELLS; i++) shadow_cells[i] = '0;
            shadow_col = 0;
            shadow_row = 0;
         end
         default: ; // unused request: state holds, cursor is reported
      endcase
      view.pos = POS_W'(shadow_row * COLUMNS + shadow_col);
      return view;
   endfunction

   // ----------------------------------------------------------------------
   // Result checker: every strobed result against the oldest expectation
   // ----------------------------------------------------------------------
   task automatic report_mismatch(input string msg);
      $display("[%0t] MISMATCH %s", $realtime, msg);
      error_count = error_count + 1;
   endtask

   always @(posedge clock) begin
      cell_report_type want;
      if (!reset && rsp_valid) begin
         reports_seen = reports_seen + 1;
         if (awaited_reports.size() == 0) begin
            report_mismatch($sformatf("result with nothing pending: pos %0d char %02h attr %02h",
                                      rsp_cursor_pos, rsp_cell_char, rsp_cell_attr));
         end else begin
            want = awaited_reports.pop_front();
            if (rsp_cursor_pos !== want.pos)
               report_mismatch($sformatf("cursor_pos got %0d want %0d",
                                         rsp_cursor_pos, want.pos));
            if (rsp_cell_char !== want.ch)
               report_mismatch($sformatf("cell_char got %02h want %02h",
                                         rsp_cell_char, want.ch));
            if (rsp_cell_attr !== want.attr)
               report_mismatch($sformatf("cell_attr got %02h want %02h",
                                         rsp_cell_attr, want.attr));
         end
      end
   end

   // ----------------------------------------------------------------------
   // Request driver
   // ----------------------------------------------------------------------
   // Present one item at the falling edge and hold it until an edge with busy
   // low takes it; start stays high so a following item can go back to back.
   task automatic send_item(input logic [REQ_W-1:0]  kind,
                            input logic [CHAR_W-1:0] code,
                            input logic [IDX_W-1:0]  addr,
                            input logic              typed,
                            input cell_report_type   typed_want);
      cell_report_type predicted;
      @(negedge clock);
      start          <= 1'b1;
      req_type       <= kind;
      req_char_code  <= code;
      req_cell_index <= addr;
      do @(posedge clock); while (busy);
      predicted = console_apply(kind, code, addr);
      awaited_reports.push_back(typed ? typed_want : predicted);
      items_sent = items_sent + 1;
   endtask

   // Drop start for the drawn number of cycles before the next item.
   task automatic hold_off(input int cycles);
      if (cycles > 0) begin
         @(negedge clock);
         start <= 1'b0;
         repeat (cycles - 1) @(negedge clock);
      end
   endtask

   // Drop start and wait until every pending result has come back.
   task automatic drain_pending();
      @(negedge clock);
      start <= 1'b0;
      while (awaited_reports.size() != 0) @(posedge clock);
   endtask

   // Only called while the block is idle.
   task automatic write_attr(input logic [ATTR_W-1:0] value);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      shadow_attr = value;
   endtask

   // Random item, mostly text with some control characters, reads near the
   // cursor and the odd clear or unused request.
   task automatic random_item(output logic [REQ_W-1:0]  kind,
                              output logic [CHAR_W-1:0] code,
                              output logic [IDX_W-1:0]  addr);
      int unsigned pick;
      int unsigned here;
      int unsigned back;
      pick = $urandom_range(0, 99);
      kind = REQ_WRITE;
      code = CHAR_W'($urandom_range(0, 255));
      addr = IDX_W'($urandom_range(0, MAX_CELL_INDEX));
      if (pick < 58) begin
         // printable or any byte
      end else if (pick < 66) begin
         code = CH_TAB;
      end else if (pick < 71) begin
         code = CH_BS;
      end else if (pick < 74) begin
         code = CH_CR;
      end else if (pick < 78) begin
         code = CH_LF;
      end else if (pick < 95) begin
         kind = REQ_READ;
         pick = $urandom_range(0, 9);
         if (pick < 6) begin
            // Look at recently written text just behind the cursor.
            here = shadow_row * COLUMNS + shadow_col;
            back = $urandom_range(0, 240);
            addr = (here >= back) ? IDX_W'(here - back)
                                  : IDX_W'($urandom_range(0, CELLS - 1));
         end else if (pick < 9) begin
            addr = IDX_W'($urandom_range(0, CELLS - 1));
         end else begin
            addr = IDX_W'($urandom_range(CELLS, MAX_CELL_INDEX));
         end
      end else if (pick < 98) begin
         kind = REQ_UNUSED;
      end else if (pick < 99) begin
         kind = REQ_CLEAR;
      end
   endtask

   // ----------------------------------------------------------------------
   // Opening table: known cases, expectations typed where obvious
   // ----------------------------------------------------------------------
   opening_row_type opening_rows [OPENING_ROWS];

   initial begin
      logic [REQ_W-1:0]  kind;
      logic [CHAR_W-1:0] code;
      logic [IDX_W-1:0]  addr;
      logic [ATTR_W-1:0] phase_attr;
      bit                gaps_on;
      int                gap;

      opening_rows = '{
         // blank screen right after reset
         '{REQ_READ,   8'h00, 11'd0,    1'b1, '{11'd0,  8'h00, 8'h00}},
         '{REQ_WRITE,  8'h41, 11'd0,    1'b1, '{11'd1,  8'h00, 8'h00}},
         // printed with the reset attribute
         '{REQ_READ,   8'h00, 11'd0,    1'b1, '{11'd1,  8'h41, ATTR_RESET}},
         // out-of-range and last cell
         '{REQ_READ,   8'hFF, 11'd2047, 1'b1, '{11'd1,  8'h00, 8'h00}},
         '{REQ_READ,   8'h00, 11'd1999, 1'b1, '{11'd1,  8'h00, 8'h00}},
         // unused request type changes nothing
         '{REQ_UNUSED, 8'hFF, 11'd2047, 1'b1, '{11'd1,  8'h00, 8'h00}},
         // backspace blanks the character, keeps the attribute
         '{REQ_WRITE,  CH_BS, 11'd0,    1'b1, '{11'd0,  8'h00, 8'h00}},
         '{REQ_READ,   8'h00, 11'd0,    1'b1, '{11'd0,  8'h00, ATTR_RESET}},
         // backspace at column zero does nothing
         '{REQ_WRITE,  CH_BS, 11'd0,    1'b1, '{11'd0,  8'h00, 8'h00}},
         '{REQ_WRITE,  CH_TAB, 11'd0,   1'b1, '{11'd8,  8'h00, 8'h00}},
         '{REQ_WRITE,  CH_CR, 11'd0,    1'b1, '{11'd0,  8'h00, 8'h00}},
         '{REQ_WRITE,  CH_LF, 11'd0,    1'b1, '{11'd80, 8'h00, 8'h00}},
         // zero byte is printed like any other
         '{REQ_WRITE,  8'h00, 11'd0,    1'b1, '{11'd81, 8'h00, 8'h00}},
         '{REQ_WRITE,  8'hFF, 11'd0,    1'b1, '{11'd82, 8'h00, 8'h00}},
         '{REQ_READ,   8'h00, 11'd80,   1'b0, '0},
         '{REQ_READ,   8'h00, 11'd81,   1'b0, '0},
         '{REQ_CLEAR,  8'h00, 11'd0,    1'b1, '{11'd0,  8'h00, 8'h00}},
         '{REQ_READ,   8'h00, 11'd81,   1'b1, '{11'd0,  8'h00, 8'h00}}
      };

      // Hold reset, then release it on a falling edge.
      shadow_reset();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Walk the opening table back to back; the RAM clearing pass after
      // reset keeps busy high for a while before the first item is taken.
      foreach (opening_rows[i])
         send_item(opening_rows[i].kind, opening_rows[i].code, opening_rows[i].addr,
                   opening_rows[i].typed, opening_rows[i].want);
      drain_pending();

      // Random phases, each under its own attribute; extremes first.
      for (int phase = 0; phase < ATTR_PHASES; phase++) begin
         case (phase)
            0:       phase_attr = 8'h00;
            1:       phase_attr = 8'hFF;
            default: phase_attr = ATTR_W'($urandom_range(0, 255));
         endcase
         write_attr(phase_attr);
         gaps_on = 1'b1;
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            // Redraw now and then whether the sender idles, so that there are
            // stretches of back-to-back items as well.
            if (n % 40 == 0) gaps_on = ($urandom_range(0, 2) != 0);
            random_item(kind, code, addr);
            send_item(kind, code, addr, 1'b0, '0);
            if ($urandom_range(0, 99) == 0) begin
               // Let the block run dry now and then.
               drain_pending();
            end else begin
               gap = gaps_on ? $urandom_range(0, 10) : 0;
               hold_off(gap);
            end
         end
         drain_pending();
      end

      // Everything has come back; give stray results a chance to show up.
      repeat (TAIL_CYCLES) @(posedge clock);
      if (awaited_reports.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", awaited_reports.size()));

      $display("covered %0d items: %0d reads, %0d clears, %0d scrolls, %0d attribute settings",
               items_sent, read_count, clear_count, scroll_count, ATTR_PHASES);
      $display("checked %0d results, %0d mismatches", reports_seen, error_count);
      if (error_count == 0) begin
         $display("text_console_writer_core_tb: done, clean");
      end else begin
         $display("text_console_writer_core_tb: done, errors");
      end
      $finish;
   end

   // Watchdog: a hang anywhere ends the run as a failure.
   initial begin
      #(RUN_LIMIT_NS);
      $display("timeout with %0d results pending", awaited_reports.size());
      $display("text_console_writer_core_tb: done, errors");
      $finish;
   end

endmodule
